// ===== hw/rtl/rart_pkg.sv =====
// Shared types and codes for the region allocation record table.
package rart_pkg;

    localparam int AddrW   = 64;
    localparam int SizeW   = 40;
    localparam int DirW    = 4;
    localparam int CountW  = 11;
    localparam int StatusW = 3;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 40;

    localparam logic [AddrW-1:0]  AddrReset   = 64'h0000_0000_0000_1000;
    localparam logic [SizeW-1:0]  BudgetReset = 40'd268435456;
    localparam logic [CountW-1:0] LimitReset  = 11'd1024;

    typedef enum logic [StatusW-1:0] {
        STATUS_OK        = 3'd0,
        STATUS_INVALID   = 3'd1,
        STATUS_CAPACITY  = 3'd2,
        STATUS_BUDGET    = 3'd3,
        STATUS_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_BYTE_BUDGET  = 2'd0,
        CFG_RECORD_LIMIT = 2'd1,
        CFG_COLUMN_CHECK = 2'd2
    } cfg_index_t;

    typedef enum logic {
        CMD_LOCATE  = 1'b0,
        CMD_RELEASE = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } rart_state_t;

    typedef struct packed {
        logic             busy;
        logic [AddrW-1:0] address;
        logic [SizeW-1:0] size;
        logic [DirW-1:0]  direction;
    } slot_entry_t;

endpackage

// ===== hw/rtl/region_allocation_record_table.sv =====
// Region allocation record table: bump allocator over a slot record memory.
//
//   channel   signals                                              direction
//   command   start, busy (out), command, request_size,            in
//             request_direction, release_address
//   result    done, status, granted_address, granted_size,         out
//             granted_direction, live_records, live_bytes
//   config    cfg_we, cfg_index, cfg_data                          in
//
// After reset a clearing pass writes every slot, with busy high.
// A locate that fails its argument, count or budget check answers in the cycle after it is accepted.
// Otherwise the slot memory is walked one entry a cycle through its read port:
// a locate stops at the first free slot, a release at the busy slot whose
// address matches, and a miss answers when the walk reaches its end.
// One result beat per command; the receiver cannot stall it.
module region_allocation_record_table #(
    parameter int TABLE_DEPTH     = 1024,
    parameter int COLUMN_LIMIT    = 24,
    parameter int DIRECTION_COUNT = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          command,
    input  logic [rart_pkg::SizeW-1:0]    request_size,
    input  logic [rart_pkg::DirW-1:0]     request_direction,
    input  logic [rart_pkg::AddrW-1:0]    release_address,
    output logic                          done,
    output logic [rart_pkg::StatusW-1:0]  status,
    output logic [rart_pkg::AddrW-1:0]    granted_address,
    output logic [rart_pkg::SizeW-1:0]    granted_size,
    output logic [rart_pkg::DirW-1:0]     granted_direction,
    output logic [rart_pkg::CountW-1:0]   live_records,
    output logic [rart_pkg::SizeW-1:0]    live_bytes,
    input  logic                          cfg_we,
    input  logic [rart_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [rart_pkg::CfgDataW-1:0] cfg_data
);
    import rart_pkg::*;

    localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CntW = $clog2(TABLE_DEPTH + 1);
    localparam int LimW = (CntW > CountW) ? CntW : CountW;
    localparam int DirCmpW = DirW + 1;

    // configuration
    logic [SizeW-1:0]  byte_budget_reg;
    logic [CountW-1:0] record_limit_reg;
    logic              column_check_reg;

    // allocator state
    rart_state_t       state_reg, state_next;
    logic [AddrW-1:0]  next_free_reg;
    logic [CountW-1:0] busy_count_reg;
    logic [SizeW-1:0]  busy_bytes_reg;

    // command held during the walk
    logic              cmd_reg;
    logic [SizeW-1:0]  size_reg;
    logic [DirW-1:0]   dir_reg;
    logic [AddrW-1:0]  addr_reg;

    // walk pointers
    logic [CntW-1:0]   ptr_reg;
    logic [CntW-1:0]   end_reg;
    logic [IdxW-1:0]   rd_idx_reg;
    logic              rd_vld_reg;

    // result beat
    logic              done_reg;
    status_t           status_reg;
    logic [AddrW-1:0]  gaddr_reg;
    logic [SizeW-1:0]  gsize_reg;
    logic [DirW-1:0]   gdir_reg;
    logic [CountW-1:0] rcount_reg;
    logic [SizeW-1:0]  rbytes_reg;

    // memory port
    logic              mem_we;
    logic [IdxW-1:0]   mem_waddr;
    slot_entry_t       mem_wdata;
    logic              mem_re;
    slot_entry_t       mem_rdata;

    logic              accept;
    logic [LimW-1:0]   limit_ext;
    logic [LimW-1:0]   eff_limit;
    logic [SizeW:0]    budget_sum;
    logic              arg_bad;
    logic              count_full;
    logic              column_full;
    logic              budget_over;
    logic              precheck_fail;
    status_t           precheck_status;
    logic              issue_more;
    logic              hit;
    logic              miss;
    logic [SizeW+1:0]  bump_step;

    assign accept = start && (state_reg == ST_IDLE);

    // checks on the incoming locate, in priority order
    always_comb
    begin
        limit_ext   = LimW'(record_limit_reg);
        eff_limit   = (limit_ext > LimW'(TABLE_DEPTH)) ? LimW'(TABLE_DEPTH) : limit_ext;
        budget_sum  = {1'b0, busy_bytes_reg} + {1'b0, request_size};
        arg_bad     = (request_size == '0)
                      || ({1'b0, request_direction} >= DirCmpW'(DIRECTION_COUNT));
        count_full  = LimW'(busy_count_reg) >= eff_limit;
        column_full = column_check_reg && (busy_count_reg >= CountW'(COLUMN_LIMIT));
        budget_over = budget_sum > {1'b0, byte_budget_reg};
        precheck_fail   = 1'b1;
        precheck_status = STATUS_INVALID;
        priority if (arg_bad)
        begin
            precheck_status = STATUS_INVALID;
        end
        else if (count_full || column_full)
        begin
            precheck_status = STATUS_CAPACITY;
        end
        else if (budget_over)
        begin
            precheck_status = STATUS_BUDGET;
        end
        else
        begin
            precheck_fail = 1'b0;
        end
    end

    // walk status
    always_comb
    begin
        issue_more = ptr_reg < end_reg;
        if (cmd_reg == CMD_LOCATE)
        begin
            hit = rd_vld_reg && !mem_rdata.busy;
        end
        else
        begin
            hit = rd_vld_reg && mem_rdata.busy && (mem_rdata.address == addr_reg);
        end
        miss = rd_vld_reg && !hit && !issue_more;
    end

    // size rounded up to 8, plus one 8-byte gap
    assign bump_step = (({2'b00, size_reg} + (SizeW+2)'(7)) & ~(SizeW+2)'(7))
                       + (SizeW+2)'(8);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (ptr_reg == CntW'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && !((command == CMD_LOCATE) && precheck_fail))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = ST_COMMIT;
                end
                else if (miss)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = rd_idx_reg;
        mem_wdata = '0;
        mem_re    = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg[IdxW-1:0];
            end
            ST_SCAN:
            begin
                mem_re = issue_more && !hit;
            end
            ST_COMMIT:
            begin
                mem_we = 1'b1;
                if (cmd_reg == CMD_LOCATE)
                begin
                    mem_wdata.busy      = 1'b1;
                    mem_wdata.address   = next_free_reg;
                    mem_wdata.size      = size_reg;
                    mem_wdata.direction = dir_reg;
                end
                else
                begin
                    mem_wdata      = mem_rdata;
                    mem_wdata.busy = 1'b0;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    rart_slot_ram #(
        .DEPTH (TABLE_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (ptr_reg[IdxW-1:0]),
        .rdata (mem_rdata)
    );

    // control and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            byte_budget_reg  <= BudgetReset;
            record_limit_reg <= LimitReset;
            column_check_reg <= 1'b1;
            next_free_reg    <= AddrReset;
            busy_count_reg   <= '0;
            busy_bytes_reg   <= '0;
            ptr_reg          <= '0;
            end_reg          <= '0;
            rd_vld_reg       <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BYTE_BUDGET:  byte_budget_reg  <= cfg_data[SizeW-1:0];
                    CFG_RECORD_LIMIT: record_limit_reg <= cfg_data[CountW-1:0];
                    CFG_COLUMN_CHECK: column_check_reg <= cfg_data[0];
                    default:          byte_budget_reg  <= byte_budget_reg;
                endcase
            end

            // no read is issued while idle, so the valid flag is already low on accept
            rd_vld_reg <= mem_re;
            if (state_reg == ST_CLEAR || mem_re)
            begin
                ptr_reg <= ptr_reg + CntW'(1);
            end

            if (accept)
            begin
                ptr_reg    <= '0;
                end_reg    <= (command == CMD_LOCATE) ? CntW'(eff_limit)
                                                      : CntW'(TABLE_DEPTH);
                if ((command == CMD_LOCATE) && precheck_fail)
                begin
                    done_reg <= 1'b1;
                end
            end

            if (state_reg == ST_SCAN && miss)
            begin
                done_reg <= 1'b1;
            end

            if (state_reg == ST_COMMIT)
            begin
                done_reg <= 1'b1;
                if (cmd_reg == CMD_LOCATE)
                begin
                    next_free_reg  <= next_free_reg + AddrW'(bump_step);
                    busy_count_reg <= busy_count_reg + CountW'(1);
                    busy_bytes_reg <= busy_bytes_reg + size_reg;
                end
                else
                begin
                    if (busy_count_reg != '0)
                    begin
                        busy_count_reg <= busy_count_reg - CountW'(1);
                    end
                    if (busy_bytes_reg >= mem_rdata.size)
                    begin
                        busy_bytes_reg <= busy_bytes_reg - mem_rdata.size;
                    end
                end
            end
        end
    end

    // command capture, read index tracking and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            size_reg <= request_size;
            dir_reg  <= request_direction;
            addr_reg <= release_address;
        end

        if (mem_re)
        begin
            rd_idx_reg <= ptr_reg[IdxW-1:0];
        end

        if (accept && (command == CMD_LOCATE) && precheck_fail)
        begin
            status_reg <= precheck_status;
            gaddr_reg  <= '0;
            gsize_reg  <= '0;
            gdir_reg   <= '0;
            rcount_reg <= busy_count_reg;
            rbytes_reg <= busy_bytes_reg;
        end
        else if (state_reg == ST_SCAN && miss)
        begin
            status_reg <= (cmd_reg == CMD_LOCATE) ? STATUS_CAPACITY : STATUS_NOT_FOUND;
            gaddr_reg  <= '0;
            gsize_reg  <= '0;
            gdir_reg   <= '0;
            rcount_reg <= busy_count_reg;
            rbytes_reg <= busy_bytes_reg;
        end
        else if (state_reg == ST_COMMIT)
        begin
            status_reg <= STATUS_OK;
            if (cmd_reg == CMD_LOCATE)
            begin
                gaddr_reg  <= next_free_reg;
                gsize_reg  <= size_reg;
                gdir_reg   <= dir_reg;
                rcount_reg <= busy_count_reg + CountW'(1);
                rbytes_reg <= busy_bytes_reg + size_reg;
            end
            else
            begin
                gaddr_reg  <= '0;
                gsize_reg  <= '0;
                gdir_reg   <= '0;
                rcount_reg <= (busy_count_reg != '0) ? busy_count_reg - CountW'(1)
                                                     : busy_count_reg;
                rbytes_reg <= (busy_bytes_reg >= mem_rdata.size)
                              ? busy_bytes_reg - mem_rdata.size : busy_bytes_reg;
            end
        end
    end

    assign busy              = (state_reg != ST_IDLE);
    assign done              = done_reg;
    assign status            = status_reg;
    assign granted_address   = gaddr_reg;
    assign granted_size      = gsize_reg;
    assign granted_direction = gdir_reg;
    assign live_records      = rcount_reg;
    assign live_bytes        = rbytes_reg;

endmodule

// ===== hw/rtl/rart_slot_ram.sv =====
// Slot record memory: one write port, one registered read port.
module rart_slot_ram #(
    parameter int DEPTH = 1024,
    localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [IdxW-1:0]       waddr,
    input  rart_pkg::slot_entry_t wdata,
    input  logic                  re,
    input  logic [IdxW-1:0]       raddr,
    output rart_pkg::slot_entry_t rdata
);
    import rart_pkg::*;

    slot_entry_t mem [DEPTH];
    slot_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
